// ----- rtl/core/servo_position_reply_parser_defines.svh -----
// Assertion macros shared by the servo reply parser RTL.
`ifndef SERVO_POSITION_REPLY_PARSER_DEFINES_SVH
`define SERVO_POSITION_REPLY_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SPRP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SPRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sprp_pkg.sv -----
// Types and constants of the servo position reply parser.
`timescale 1ns / 1ps
`default_nettype none

package sprp_pkg;

    typedef enum logic [2:0] {
        VERDICT_OK    = 3'd0,
        VERDICT_FRAME = 3'd1,
        VERDICT_ID    = 3'd2,
        VERDICT_CMD   = 3'd3,
        VERDICT_SUM   = 3'd4,
        VERDICT_RANGE = 3'd5
    } t_verdict;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_BYTE  = 1'b1
    } t_command;

    typedef enum logic {
        REG_REPLY_COMMAND = 1'b0,
        REG_MAX_POSITION  = 1'b1
    } t_reg_index;

    localparam logic [7:0]  FRAME_HEADER        = 8'h55;
    localparam logic [7:0]  FRAME_LEN_FIELD     = 8'd5;
    localparam int          FRAME_BYTES         = 8;
    localparam logic [7:0]  REPLY_COMMAND_RESET = 8'd28;
    localparam logic [15:0] MAX_POSITION_RESET  = 16'd1000;

endpackage

`default_nettype wire

// ----- rtl/core/servo_position_reply_parser.sv -----
// Top level of the servo position reply parser.
`timescale 1ns / 1ps
`default_nettype none
`include "servo_position_reply_parser_defines.svh"

// Usage
// The input channel carries one item per handshake: a start item (command 0)
// clears the search and takes the servo id, a byte item (command 1) brings one
// received byte. Every accepted item yields exactly one result item on the
// output channel, showing verdict, found flag and position after that item.
// The result appears in the cycle after acceptance. Unless the output stalls,
// one item per cycle is sustained; the frame check over the eight-byte window is
// a single level of compares and a five-byte sum between the state registers.
// The state registers themselves form the output register, so while a result
// waits under stall the input is stalled too, and the block resumes taking an
// item in the same cycle that the waiting result is taken.
// Synchronous active-low reset empties the window, clears the byte count,
// found flag and position, sets the verdict to frame error, the target id to
// zero, and loads the configuration registers with their reset values.
// The user must write configuration over the APB-style port only while the
// block is idle; the block itself does not enforce it. Register 0 (reply
// command) lies at byte address 0, register 1 (maximum position) at byte address 4.
module servo_position_reply_parser
    import sprp_pkg::*;
#(
    parameter int BUFFER_BYTES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_command,
    input  wire logic [7:0]  i_expected_id,
    input  wire logic [7:0]  i_rx_byte,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_verdict,
    output logic             o_found,
    output logic [15:0]      o_position,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // The count must be able to hold the buffer length itself.
    localparam int CW = $clog2(BUFFER_BYTES + 1);

    // Configuration registers.
    logic [7:0]  r_reply_command;
    logic [15:0] r_max_position;

    // Search state; verdict, found and position double as the result register.
    logic [7:0]    r_window [0:FRAME_BYTES-1];
    logic [CW-1:0] r_count;
    logic [7:0]    r_target_id;
    t_verdict      r_verdict;
    logic          r_found;
    logic [15:0]   r_position;
    logic          r_out_valid;

    logic [7:0]    n_window [0:FRAME_BYTES-1];
    logic [CW-1:0] n_count;
    logic [7:0]    n_target_id;
    t_verdict      n_verdict;
    logic          n_found;
    logic [15:0]   n_position;

    logic          in_accept;
    logic          out_accept;
    logic          cfg_write;
    logic          byte_taken;
    logic [7:0]    frame_sum;
    logic [15:0]   frame_pos;

    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign out_accept = r_out_valid && !i_out_stall;
    // A waiting result holds the state, so a new item waits with it.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        case (t_reg_index'(paddr[2]))
            REG_REPLY_COMMAND: prdata = {24'd0, r_reply_command};
            REG_MAX_POSITION:  prdata = {16'd0, r_max_position};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reply_command <= REPLY_COMMAND_RESET;
            r_max_position  <= MAX_POSITION_RESET;
        end else if (cfg_write) begin
            case (t_reg_index'(paddr[2]))
                REG_REPLY_COMMAND: r_reply_command <= pwdata[7:0];
                REG_MAX_POSITION:  r_max_position  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Bytes are taken only while the buffer still has room.
    assign byte_taken = (t_command'(i_command) == CMD_BYTE) &&
                        (r_count < CW'(BUFFER_BYTES));

    // The shifted window holds the newest byte at the last place.
    always_comb begin
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            n_window[i] = r_window[i + 1];
        end
        n_window[FRAME_BYTES - 1] = i_rx_byte;
    end

    // Checksum covers id, length, command and both position bytes.
    assign frame_sum = n_window[2] + n_window[3] + n_window[4] + n_window[5] + n_window[6];
    assign frame_pos = {n_window[6], n_window[5]};

    always_comb begin
        n_count     = r_count;
        n_target_id = r_target_id;
        n_verdict   = r_verdict;
        n_found     = r_found;
        n_position  = r_position;
        if (t_command'(i_command) == CMD_START) begin
            n_count     = '0;
            n_target_id = i_expected_id;
            n_verdict   = VERDICT_FRAME;
            n_found     = 1'b0;
            n_position  = 16'd0;
        end else if (byte_taken) begin
            n_count = r_count + CW'(1);
            // A window with bad headers or length leaves the verdict alone;
            // once a good frame is latched nothing changes it.
            if ((n_count >= CW'(FRAME_BYTES)) && !r_found &&
                (n_window[0] == FRAME_HEADER) && (n_window[1] == FRAME_HEADER) &&
                (n_window[3] == FRAME_LEN_FIELD)) begin
                if (n_window[2] != r_target_id) begin
                    n_verdict = VERDICT_ID;
                end else if (n_window[4] != r_reply_command) begin
                    n_verdict = VERDICT_CMD;
                end else if (~frame_sum != n_window[FRAME_BYTES - 1]) begin
                    n_verdict = VERDICT_SUM;
                end else if (frame_pos > r_max_position) begin
                    n_verdict = VERDICT_RANGE;
                end else begin
                    n_verdict  = VERDICT_OK;
                    n_found    = 1'b1;
                    n_position = frame_pos;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FRAME_BYTES; i++) begin
                r_window[i] <= 8'd0;
            end
            r_count     <= '0;
            r_target_id <= 8'd0;
            r_verdict   <= VERDICT_FRAME;
            r_found     <= 1'b0;
            r_position  <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                if (t_command'(i_command) == CMD_START) begin
                    for (int i = 0; i < FRAME_BYTES; i++) begin
                        r_window[i] <= 8'd0;
                    end
                end else if (byte_taken) begin
                    for (int i = 0; i < FRAME_BYTES; i++) begin
                        r_window[i] <= n_window[i];
                    end
                end
                r_count     <= n_count;
                r_target_id <= n_target_id;
                r_verdict   <= n_verdict;
                r_found     <= n_found;
                r_position  <= n_position;
                r_out_valid <= 1'b1;
            end else if (out_accept) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;
    assign o_found     = r_found;
    assign o_position  = r_position;

    `SPRP_ASSERT_NOW(a_found_means_ok, i_clk, i_rst_n, r_found, r_verdict == VERDICT_OK, "found set without an OK verdict")
    `SPRP_ASSERT_NOW(a_position_zero_unless_found, i_clk, i_rst_n, !r_found, r_position == 16'd0, "position reported without a latched frame")
    `SPRP_ASSERT_NEXT(a_found_sticky, i_clk, i_rst_n, r_found && !(in_accept && (t_command'(i_command) == CMD_START)), r_found, "found flag dropped without a start item")
    `SPRP_ASSERT_NOW(a_count_bounded, i_clk, i_rst_n, 1'b1, r_count <= CW'(BUFFER_BYTES), "byte count ran past the buffer length")

endmodule

`default_nettype wire

// ----- test/servo_position_reply_parser_test.sv -----
// Self-checking testbench for the servo position reply parser.
`timescale 1ns / 1ps

// The bench offers start and byte items to the parser and predicts each reply
// with its own model of the eight-byte window. Every reply taken from the
// block is compared field by field with the oldest prediction. A short
// directed sequence comes first. Random searches follow under four settings
// of the reply command and position limit registers. Both handshakes idle at
// random, and once the receiver holds off long enough for the block to stall
// its input.
module servo_position_reply_parser_test;
    import sprp_pkg::*;

    localparam int BUFFER_BYTES     = 16;
    localparam int RANDOM_PER_PHASE = 85;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LATENCY_PAUSE    = 3;
    localparam int PRESSURE_AFTER   = 60;
    localparam int LONG_HOLD        = 120;
    localparam int TX_SIDE          = 0;
    localparam int RX_SIDE          = 1;

    // Ways in which a generated reply frame may be spoilt.
    typedef enum int {
        FLAW_NONE,
        FLAW_HEAD0,
        FLAW_HEAD1,
        FLAW_LENGTH,
        FLAW_ID,
        FLAW_CMD,
        FLAW_SUM
    } t_flaw;

    typedef struct packed {
        t_command   command;
        logic [7:0] expected_id;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        t_verdict    verdict;
        logic        found;
        logic [15:0] position;
    } t_reply;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        item_cmd = 1'b0;
    logic [7:0]  item_id = 8'h00;
    logic [7:0]  item_byte = 8'h00;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  out_verdict;
    logic        out_found;
    logic [15:0] out_position;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Items waiting to be offered, and replies predicted but not yet seen.
    t_item  pending [$];
    t_reply replies_due [$];

    // Handshake flags from the last rising edge, read by the driving processes.
    logic item_taken = 1'b0;
    logic result_taken = 1'b0;

    int errors = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int calm_left [2] = '{0, 0};

    // Predicted parser state and its copy of the configuration registers.
    logic [7:0]  win [FRAME_BYTES] = '{default: 8'h00};
    int          bytes_held = 0;
    logic [7:0]  search_id = 8'h00;
    t_verdict    verdict_q = VERDICT_FRAME;
    logic        found_q = 1'b0;
    logic [15:0] position_q = 16'd0;
    logic [7:0]  cfg_command = REPLY_COMMAND_RESET;
    logic [15:0] cfg_max_position = MAX_POSITION_RESET;

    servo_position_reply_parser #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_command(item_cmd),
        .i_expected_id(item_id),
        .i_rx_byte(item_byte),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_verdict(out_verdict),
        .o_found(out_found),
        .o_position(out_position),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // Works out the reply that an item causes and advances the predicted state.
    // A start clears the search; a byte is shifted in unless the buffer is full,
    // and from the eighth byte on the window is checked until a frame is found.
    function automatic t_reply next_reply(t_item it);
        logic [7:0]  check_byte;
        logic [15:0] pos;
        int          k;
        t_reply      r;
        if (it.command == CMD_START) begin
            win = '{default: 8'h00};
            bytes_held = 0;
            verdict_q = VERDICT_FRAME;
            found_q = 1'b0;
            position_q = 16'd0;
            search_id = it.expected_id;
        end else if (bytes_held < BUFFER_BYTES) begin
            for (k = 0; k < FRAME_BYTES - 1; k++) begin
                win[k] = win[k + 1];
            end
            win[FRAME_BYTES - 1] = it.rx_byte;
            bytes_held++;
            check_byte = ~(win[2] + win[3] + win[4] + win[5] + win[6]);
            pos = {win[6], win[5]};
            // A window with a bad header or length leaves the verdict alone.
            if (bytes_held >= FRAME_BYTES && !found_q && win[0] == FRAME_HEADER
                    && win[1] == FRAME_HEADER && win[3] == FRAME_LEN_FIELD) begin
                if (win[2] != search_id) begin
                    verdict_q = VERDICT_ID;
                end else if (win[4] != cfg_command) begin
                    verdict_q = VERDICT_CMD;
                end else if (win[7] != check_byte) begin
                    verdict_q = VERDICT_SUM;
                end else if (pos > cfg_max_position) begin
                    verdict_q = VERDICT_RANGE;
                end else begin
                    verdict_q = VERDICT_OK;
                    found_q = 1'b1;
                    position_q = pos;
                end
            end
        end
        r.verdict = verdict_q;
        r.found = found_q;
        r.position = position_q;
        return r;
    endfunction

    // Length of an idle stretch for one side: mostly none or short, now and
    // then long, with occasional runs of items that see no idling at all.
    function automatic int pick_pause(int side);
        int roll;
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            calm_left[side] = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 8'h00;
        if (roll == 1) return 8'hFF;
        if (roll == 2) return FRAME_HEADER;
        return 8'($urandom_range(0, 255));
    endfunction

    // The field that the command does not use carries random content.
    function automatic void queue_item(t_command c, logic [7:0] value);
        t_item it;
        it.command = c;
        it.expected_id = (c == CMD_START) ? value : 8'($urandom_range(0, 255));
        it.rx_byte = (c == CMD_BYTE) ? value : 8'($urandom_range(0, 255));
        pending.push_back(it);
    endfunction

    // Queues one reply frame. Id and command flaws are made before the
    // checksum is formed, so that they are seen as what they are.
    function automatic void queue_frame(logic [7:0] id, logic [7:0] cmd,
                                        logic [15:0] pos, t_flaw flaw);
        logic [7:0] f [FRAME_BYTES];
        logic [7:0] spoil;
        int         k;
        spoil = 8'($urandom_range(1, 255));
        f = '{FRAME_HEADER, FRAME_HEADER, id, FRAME_LEN_FIELD, cmd,
              pos[7:0], pos[15:8], 8'h00};
        if (flaw == FLAW_ID) f[2] = f[2] ^ spoil;
        if (flaw == FLAW_CMD) f[4] = f[4] ^ spoil;
        f[7] = ~(f[2] + f[3] + f[4] + f[5] + f[6]);
        case (flaw)
            FLAW_HEAD0: f[0] = f[0] ^ spoil;
            FLAW_HEAD1: f[1] = f[1] ^ spoil;
            FLAW_LENGTH: f[3] = f[3] ^ spoil;
            FLAW_SUM: f[7] = f[7] ^ spoil;
            default: ;
        endcase
        for (k = 0; k < FRAME_BYTES; k++) begin
            queue_item(CMD_BYTE, f[k]);
        end
    endfunction

    // One search: a start, then one or two frames with noise around them.
    // Trailing noise may run past the buffer and be ignored.
    function automatic void queue_search();
        logic [7:0]  id;
        logic [15:0] pos;
        t_flaw       flaw;
        int          roll;
        id = pick_byte();
        queue_item(CMD_START, id);
        repeat ($urandom_range(1, 2)) begin
            repeat ($urandom_range(0, 3)) queue_item(CMD_BYTE, pick_byte());
            roll = $urandom_range(0, 5);
            if (roll == 0) pos = cfg_max_position;
            else if (roll == 1) pos = (cfg_max_position == 16'hFFFF) ? cfg_max_position
                                                                     : cfg_max_position + 16'd1;
            else if (roll == 2) pos = 16'd0;
            else if (roll == 3) pos = 16'hFFFF;
            else pos = 16'($urandom_range(0, cfg_max_position));
            roll = $urandom_range(0, 9);
            flaw = (roll > FLAW_SUM) ? FLAW_NONE : t_flaw'(roll);
            queue_frame(id, cfg_command, pos, flaw);
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) queue_item(CMD_BYTE, pick_byte());
        end
    endfunction

    // Returns once every item is in and every reply is out, plus a short pause.
    task automatic settle();
        while (pending.size() != 0 || in_valid || replies_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (LATENCY_PAUSE) @(posedge clk);
    endtask

    // A setup cycle and an access cycle; the predictor follows on completion.
    task automatic write_register(t_reg_index idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_REPLY_COMMAND: cfg_command = value[7:0];
            REG_MAX_POSITION: cfg_max_position = value[15:0];
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(logic [7:0] cmd, logic [15:0] limit);
        write_register(REG_REPLY_COMMAND, {24'd0, cmd});
        write_register(REG_MAX_POSITION, {16'd0, limit});
        while (pending.size() < RANDOM_PER_PHASE) queue_search();
        settle();
    endtask

    // Sender. An item stays on the port until it is taken; after that the
    // chosen gap runs out before the next one is offered.
    always @(negedge clk) begin : drive_items
        bit    offer;
        t_item nxt;
        int    gap_left;
        if (rst_n) begin
            offer = in_valid && !item_taken;
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending.size() > 0) begin
                    nxt = pending.pop_front();
                    item_cmd <= nxt.command;
                    item_id <= nxt.expected_id;
                    item_byte <= nxt.rx_byte;
                    offer = 1'b1;
                    gap_left = pick_pause(TX_SIDE);
                end
            end
            in_valid <= offer;
        end
    end

    // Receiver. A pause may follow each reply taken. Once, after a number of
    // replies, it holds off long enough for the output register to fill and
    // the block to stall the sender, who keeps offering throughout.
    always @(negedge clk) begin : accept_replies
        int hold_left;
        bit pressure_done;
        if (rst_n) begin
            if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
                pressure_done = 1'b1;
                hold_left = LONG_HOLD;
            end else if (hold_left == 0 && result_taken) begin
                hold_left = pick_pause(RX_SIDE);
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Checker. A reply taken at this edge belongs to an item taken at an
    // earlier edge, so it is compared before this edge's item is predicted.
    always @(posedge clk) begin : check_replies
        t_item  seen;
        t_reply got;
        t_reply want;
        bit     took_item;
        bit     took_reply;
        took_item = rst_n && in_valid && !in_stall;
        took_reply = rst_n && out_valid && !out_stall;
        item_taken <= took_item;
        result_taken <= took_reply;
        if (took_reply) begin
            results_seen++;
            got.verdict = t_verdict'(out_verdict);
            got.found = out_found;
            got.position = out_position;
            if (replies_due.size() == 0) begin
                $display("%0t: expected no reply, got verdict %0d found %0d position %0d",
                         $time, got.verdict, got.found, got.position);
                errors++;
            end else begin
                want = replies_due.pop_front();
                if (got.verdict !== want.verdict) begin
                    $display("%0t: verdict expected %0d, got %0d",
                             $time, want.verdict, got.verdict);
                    errors++;
                end
                if (got.found !== want.found) begin
                    $display("%0t: found expected %0d, got %0d", $time, want.found, got.found);
                    errors++;
                end
                if (got.position !== want.position) begin
                    $display("%0t: position expected %0d, got %0d",
                             $time, want.position, got.position);
                    errors++;
                end
            end
        end
        if (took_item) begin
            seen.command = t_command'(item_cmd);
            seen.expected_id = item_id;
            seen.rx_byte = item_byte;
            replies_due.push_back(next_reply(seen));
        end
        idle_cycles = (took_item || took_reply) ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Bytes before any start are parsed with a target id of zero.
        queue_item(CMD_BYTE, 8'h00);
        queue_item(CMD_BYTE, 8'hFF);
        // A frame one above the position limit, then a good one at the limit;
        // the windows in between have bad headers and keep the range verdict.
        queue_item(CMD_START, 8'hFF);
        queue_frame(8'hFF, REPLY_COMMAND_RESET, MAX_POSITION_RESET + 16'd1, FLAW_NONE);
        queue_frame(8'hFF, REPLY_COMMAND_RESET, MAX_POSITION_RESET, FLAW_NONE);
        // The buffer is full now, so this byte is ignored.
        queue_item(CMD_BYTE, FRAME_HEADER);
        // A fresh search that stops short of eight bytes.
        queue_item(CMD_START, 8'h00);
        queue_item(CMD_BYTE, FRAME_HEADER);
        queue_item(CMD_BYTE, FRAME_HEADER);
        queue_item(CMD_BYTE, 8'h00);
        queue_item(CMD_BYTE, FRAME_LEN_FIELD);
        settle();

        // Random searches under the reset settings, then at both extremes and
        // at a random setting.
        while (pending.size() < RANDOM_PER_PHASE) queue_search();
        settle();
        run_phase(8'h00, 16'h0000);
        run_phase(8'hFF, 16'hFFFF);
        run_phase(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));

        repeat (LATENCY_PAUSE) @(posedge clk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/sprp_pkg.sv
rtl/core/servo_position_reply_parser.sv
test/servo_position_reply_parser_test.sv
